// ===== sv/pngunf_pkg.sv =====
// Shared types and constants for the PNG RGB unfilter with Adler-32 block.
package pngunf_pkg;

  localparam int MAX_WIDTH       = 256;
  localparam int ROW_BYTES_MAX   = 3 * MAX_WIDTH;
  localparam int POS_W           = $clog2(ROW_BYTES_MAX);
  localparam int RB_W            = $clog2(ROW_BYTES_MAX + 1);
  localparam int CMP_W           = (RB_W > 10) ? RB_W : 10;
  localparam int X_W             = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int FIFO_DEPTH      = 2;
  localparam int FIFO_PTR_W      = 1;
  localparam int FIFO_CNT_W      = 2;
  localparam int PADDR_W         = 3;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  typedef enum logic [1:0] {
    KindPixel    = 2'd0,
    KindError    = 2'd1,
    KindChecksum = 2'd2
  } kind_e;

  typedef enum logic {
    ErrFilter   = 1'b0,
    ErrPastLast = 1'b1
  } err_e;

  typedef enum logic [2:0] {
    FiltNone  = 3'd0,
    FiltSub   = 3'd1,
    FiltUp    = 3'd2,
    FiltAvg   = 3'd3,
    FiltPaeth = 3'd4
  } filter_e;

  typedef enum logic {
    CmdData  = 1'b0,
    CmdCheck = 1'b1
  } cmd_e;

  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    OpData  = 2'd0,
    OpCheck = 2'd1,
    OpError = 2'd2
  } op_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
    logic [31:0] stored_checksum;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
    logic        error_code;
    logic        checksum_ok;
    logic [31:0] computed_checksum;
  } out_t;

  typedef struct packed {
    op_e              kind;
    logic [POS_W-1:0] pos;
    logic [1:0]       ch;
    logic [X_W-1:0]   x;
    filter_e          filt;
    logic [7:0]       data;
    logic             emit;
    logic             last;
    logic [15:0]      y;
    err_e             err;
    logic             ok;
    logic [31:0]      sum;
  } op_t;

  typedef struct packed {
    logic fifo_full;
    logic clr_busy;
  } front_stat_t;

endpackage

// ===== sv/png_rgb_unfilter_with_adler_unit.sv =====
// Top level of the PNG RGB scanline unfilter with running Adler-32.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one request per
// cycle: an inflated stream byte (command 0) or a checksum check (command 1).
// Output channel (out_valid_o/out_ready_i/out_data_o) delivers at most one
// result per request: a pixel on the blue byte of each pixel, an error, or a
// checksum verdict. Valid filter bytes and red/green bytes give no result.
// An accepted request passes through the queue, the request register with
// the line store read, and the result register; sustained rate is one request
// per cycle when the output is free, set by the single line store read per byte.
// The front part tracks row position, row count and the Adler-32; a two-entry
// queue separates it from the back part, which reads the line store, runs the
// Sub/Up/Average/Paeth predictor and holds the result register.
// After reset the 768-entry line store is cleared, one entry per cycle;
// in_ready_o stays low while it is cleared, configuration writes go on.
// When the receiver stalls the result register holds, the queue fills and
// in_ready_o drops. After an error the block stays silent until reset.
// image_width (offset 0) and image_height (offset 4) are written over APB; the user
// must write them only while the block is idle, the block does not enforce it.
module png_rgb_unfilter_with_adler_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  pngunf_pkg::in_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pngunf_pkg::out_t                   out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pngunf_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [8:0]              width_q;
  logic [15:0]             height_q;
  logic                    cfg_we;
  pngunf_pkg::front_stat_t stat;
  logic                    push, pop, empty, full, clr_busy;
  pngunf_pkg::op_t         op, head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == pngunf_pkg::RegHeight) begin
      prdata = {16'd0, height_q};
    end else begin
      prdata = {23'd0, width_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 16'd256;
    end else if (cfg_we) begin
      if (paddr[2] == pngunf_pkg::RegHeight) begin
        height_q <= pwdata[15:0];
      end else begin
        width_q <= pwdata[8:0];
      end
    end
  end

  assign stat.fifo_full = full;
  assign stat.clr_busy  = clr_busy;

  pngunf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .stat_i         (stat),
    .push_o         (push),
    .op_o           (op)
  );

  pngunf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  pngunf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/pngunf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pngunf_fifo.sv =====
// Two-entry request queue between the front and back parts.
module pngunf_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pngunf_pkg::op_t   op_i,
  input  logic              pop_i,
  output pngunf_pkg::op_t   head_o,
  output logic              empty_o,
  output logic              full_o
);

  pngunf_pkg::op_t                   ent_q [pngunf_pkg::FIFO_DEPTH];
  logic [pngunf_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [pngunf_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == pngunf_pkg::FIFO_CNT_W'(pngunf_pkg::FIFO_DEPTH));
  assign head_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= op_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

// ===== sv/pngunf_front.sv =====
// Front part: accepts requests, tracks scanline position, rows and Adler-32.
module pngunf_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pngunf_pkg::in_t         in_data_i,
  input  logic [8:0]              image_width_i,
  input  logic [15:0]             image_height_i,
  input  pngunf_pkg::front_stat_t stat_i,
  output logic                    push_o,
  output pngunf_pkg::op_t         op_o
);

  localparam int CW = pngunf_pkg::CMP_W;

  logic                         halted_q, halted_d;
  logic                         await_q, await_d;
  pngunf_pkg::filter_e          filt_q, filt_d;
  logic [pngunf_pkg::POS_W-1:0] pos_q, pos_d;
  logic [1:0]                   ch_q, ch_d;
  logic [pngunf_pkg::X_W-1:0]   x_q, x_d;
  logic [15:0]                  rows_q, rows_d;
  logic [15:0]                  lo_q, lo_d, hi_q, hi_d;

  logic        accept;
  logic [16:0] lo_sum, hi_sum, lo_mod;
  logic [CW-1:0] w_ext, w_eff, row_bytes, pos_next;
  logic          row_end;
  logic [31:0]   sum;

  assign in_ready_o = !stat_i.fifo_full && !stat_i.clr_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign sum        = {hi_q, lo_q};

  assign lo_sum = {1'b0, lo_q} + {9'd0, in_data_i.data_byte};
  assign lo_mod = (lo_sum >= pngunf_pkg::ADLER_MOD) ? lo_sum - pngunf_pkg::ADLER_MOD : lo_sum;
  assign hi_sum = {1'b0, hi_q} + lo_mod;

  assign w_ext     = CW'(image_width_i);
  assign w_eff     = (w_ext == '0) ? CW'(1) :
                     ((w_ext > CW'(pngunf_pkg::MAX_WIDTH)) ? CW'(pngunf_pkg::MAX_WIDTH) : w_ext);
  assign row_bytes = w_eff + (w_eff << 1);
  assign pos_next  = CW'(pos_q) + CW'(1);
  assign row_end   = (pos_next >= row_bytes);

  always_comb begin
    halted_d = halted_q;
    await_d  = await_q;
    filt_d   = filt_q;
    pos_d    = pos_q;
    ch_d     = ch_q;
    x_d      = x_q;
    rows_d   = rows_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    push_o   = 1'b0;
    op_o     = '0;
    op_o.kind = pngunf_pkg::OpData;
    op_o.filt = filt_q;
    op_o.err  = pngunf_pkg::ErrFilter;
    op_o.pos  = pos_q;
    op_o.ch   = ch_q;
    op_o.x    = x_q;
    op_o.y    = rows_q;
    op_o.data = in_data_i.data_byte;
    op_o.sum  = sum;
    op_o.ok   = (sum == in_data_i.stored_checksum);
    if (accept && !halted_q) begin
      if (in_data_i.command == pngunf_pkg::CmdCheck) begin
        push_o    = 1'b1;
        op_o.kind = pngunf_pkg::OpCheck;
      end else if (rows_q >= image_height_i) begin
        push_o    = 1'b1;
        op_o.kind = pngunf_pkg::OpError;
        op_o.err  = pngunf_pkg::ErrPastLast;
        halted_d  = 1'b1;
      end else begin
        lo_d = lo_mod[15:0];
        hi_d = (hi_sum >= pngunf_pkg::ADLER_MOD) ? 16'(hi_sum - pngunf_pkg::ADLER_MOD)
                                                 : hi_sum[15:0];
        if (await_q) begin
          if (in_data_i.data_byte > 8'(pngunf_pkg::FiltPaeth)) begin
            push_o    = 1'b1;
            op_o.kind = pngunf_pkg::OpError;
            op_o.err  = pngunf_pkg::ErrFilter;
            halted_d  = 1'b1;
          end else begin
            filt_d  = pngunf_pkg::filter_e'(in_data_i.data_byte[2:0]);
            await_d = 1'b0;
            pos_d   = '0;
            ch_d    = '0;
            x_d     = '0;
          end
        end else begin
          push_o    = 1'b1;
          op_o.emit = (ch_q == 2'd2);
          op_o.last = (ch_q == 2'd2) && row_end &&
                      ({1'b0, rows_q} + 17'd1 == {1'b0, image_height_i});
          if (row_end) begin
            rows_d  = rows_q + 16'd1;
            await_d = 1'b1;
            pos_d   = '0;
          end else begin
            pos_d = pos_next[pngunf_pkg::POS_W-1:0];
            if (ch_q == 2'd2) begin
              ch_d = '0;
              x_d  = x_q + 1'b1;
            end else begin
              ch_d = ch_q + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      await_q  <= 1'b1;
      filt_q   <= pngunf_pkg::FiltNone;
      pos_q    <= '0;
      ch_q     <= '0;
      x_q      <= '0;
      rows_q   <= '0;
      lo_q     <= 16'd1;
      hi_q     <= '0;
    end else begin
      halted_q <= halted_d;
      await_q  <= await_d;
      filt_q   <= filt_d;
      pos_q    <= pos_d;
      ch_q     <= ch_d;
      x_q      <= x_d;
      rows_q   <= rows_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !push_o)
    else $error("request queued after halt");

endmodule

// ===== sv/pngunf_back.sv =====
// Back part: line store, unfilter arithmetic, pixel assembly and result register.
module pngunf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pngunf_pkg::op_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            clr_busy_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pngunf_pkg::out_t out_data_o
);

  localparam int PW = pngunf_pkg::POS_W;

  logic             clr_busy_q;
  logic [PW-1:0]    clr_cnt_q;
  logic             r_valid_q;
  pngunf_pkg::op_t  r_op_q;
  logic             out_valid_q;
  pngunf_pkg::out_t out_q, out_d;
  logic [7:0]       left_q [3];
  logic [7:0]       upleft_q [3];
  logic [15:0]      pp_q;

  logic       r_res, out_free, r_adv, is_data, x_nz;
  logic       ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0] ram_wdata, b, a, c, a_raw, c_raw, pred, v;
  logic [9:0] p, pa, pb, pc, ta, tb, tc;
  logic [8:0] avg_sum;

  assign is_data  = (r_op_q.kind == pngunf_pkg::OpData);
  assign r_res    = !is_data || r_op_q.emit;
  assign out_free = !out_valid_q || out_ready_i;
  assign r_adv    = r_valid_q && (!r_res || out_free);
  assign pop_o    = !empty_i && !clr_busy_q && (!r_valid_q || r_adv);

  assign ram_we    = clr_busy_q || (r_adv && is_data);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : r_op_q.pos;
  assign ram_wdata = clr_busy_q ? 8'd0 : v;

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (pngunf_pkg::ROW_BYTES_MAX)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (head_i.pos),
    .rdata_o (b)
  );

  always_comb begin
    case (r_op_q.ch)
      2'd0:    begin a_raw = left_q[0]; c_raw = upleft_q[0]; end
      2'd1:    begin a_raw = left_q[1]; c_raw = upleft_q[1]; end
      2'd2:    begin a_raw = left_q[2]; c_raw = upleft_q[2]; end
      default: begin a_raw = 8'd0;      c_raw = 8'd0;        end
    endcase
  end

  assign x_nz    = (r_op_q.x != '0);
  assign a       = x_nz ? a_raw : 8'd0;
  assign c       = x_nz ? c_raw : 8'd0;
  assign avg_sum = {1'b0, a} + {1'b0, b};

  assign p  = {2'b0, a} + {2'b0, b} + 10'd255 - {2'b0, c};
  assign ta = {2'b0, a} + 10'd255;
  assign tb = {2'b0, b} + 10'd255;
  assign tc = {2'b0, c} + 10'd255;
  assign pa = (p > ta) ? p - ta : ta - p;
  assign pb = (p > tb) ? p - tb : tb - p;
  assign pc = (p > tc) ? p - tc : tc - p;

  always_comb begin
    case (r_op_q.filt)
      pngunf_pkg::FiltSub:   pred = a;
      pngunf_pkg::FiltUp:    pred = b;
      pngunf_pkg::FiltAvg:   pred = avg_sum[8:1];
      pngunf_pkg::FiltPaeth: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:               pred = 8'd0;
    endcase
  end

  assign v = r_op_q.data + pred;

  always_comb begin
    out_d = '0;
    case (r_op_q.kind)
      pngunf_pkg::OpCheck: begin
        out_d.kind              = pngunf_pkg::KindChecksum;
        out_d.checksum_ok       = r_op_q.ok;
        out_d.computed_checksum = r_op_q.sum;
      end
      pngunf_pkg::OpError: begin
        out_d.kind       = pngunf_pkg::KindError;
        out_d.error_code = r_op_q.err;
      end
      default: begin
        out_d.kind       = pngunf_pkg::KindPixel;
        out_d.pixel_x    = 8'(r_op_q.x);
        out_d.pixel_y    = r_op_q.y;
        out_d.red        = pp_q[7:0];
        out_d.green      = pp_q[15:8];
        out_d.blue       = v;
        out_d.last_pixel = r_op_q.last;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == PW'(pngunf_pkg::ROW_BYTES_MAX - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (pop_o) begin
        r_valid_q <= 1'b1;
      end else if (r_adv) begin
        r_valid_q <= 1'b0;
      end
      if (r_adv && r_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      r_op_q <= head_i;
    end
    if (r_adv && r_res) begin
      out_q <= out_d;
    end
    if (r_adv && is_data) begin
      case (r_op_q.ch)
        2'd0: begin
          left_q[0]   <= v;
          upleft_q[0] <= b;
          pp_q        <= {8'd0, v};
        end
        2'd1: begin
          left_q[1]   <= v;
          upleft_q[1] <= b;
          pp_q[15:8]  <= v;
        end
        2'd2: begin
          left_q[2]   <= v;
          upleft_q[2] <= b;
        end
        default: begin
        end
      endcase
    end
  end

  assign clr_busy_o  = clr_busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !r_valid_q && !out_valid_q)
    else $error("request in flight during line store clear");

  a_emit_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_q && r_op_q.emit |-> r_op_q.ch == 2'd2 && is_data)
    else $error("pixel emitted on a byte other than blue");

endmodule
